>>> rtl/coap_mp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoAP message parser package
// Item types, event and status codes, protocol constants, and parser phases for the byte parser.
// ----------------------------------------------------------------------------
package coap_mp_pkg;

	// Result event codes
	localparam logic [2:0] EV_HEADER  = 3'd0;
	localparam logic [2:0] EV_TOKEN   = 3'd1;
	localparam logic [2:0] EV_OPT     = 3'd2;
	localparam logic [2:0] EV_VALUE   = 3'd3;
	localparam logic [2:0] EV_PAYLOAD = 3'd4;
	localparam logic [2:0] EV_STATUS  = 3'd5;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_VER = 2'd1;
	localparam logic [1:0] ST_FORMAT  = 2'd2;

	// Protocol constants
	localparam logic [1:0]  COAP_VERSION   = 2'd1;
	localparam logic [3:0]  MAX_TKL        = 4'd8;
	localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
	localparam logic [3:0]  NIB_EXT8       = 4'd13;
	localparam logic [3:0]  NIB_EXT16      = 4'd14;
	localparam logic [3:0]  NIB_RESERVED   = 4'd15;
	localparam logic [16:0] EXT8_BIAS      = 17'd13;
	localparam logic [16:0] EXT16_BIAS     = 17'd269;

	typedef enum logic [3:0] {
		PH_H0,
		PH_H1,
		PH_H2,
		PH_H3,
		PH_TOKEN,
		PH_OPT,
		PH_DX1,
		PH_DX2HI,
		PH_DX2LO,
		PH_LX1,
		PH_LX2HI,
		PH_LX2LO,
		PH_VALUE,
		PH_PAYLOAD,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [1:0]  version;
		logic [1:0]  msg_type;
		logic [3:0]  token_length;
		logic [2:0]  code_class;
		logic [4:0]  code_detail;
		logic [15:0] msg_ident;
		logic [15:0] option_number;
		logic [16:0] option_length;
		logic [7:0]  out_byte;
		logic        message_done;
		logic [1:0]  status;
	} res_item_t;

endpackage

>>> rtl/coap_message_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoAP message parser core
// Parses one datagram byte per item: header fields, token bytes, options
// with absolute numbers and lengths, option values and payload bytes.
// ----------------------------------------------------------------------------
//
//  channel | direction | payload      | handshake
//  --------+-----------+--------------+-------------------------------
//  byte    | in        | byte_item_t  | byte_valid / byte_stall
//  res     | out       | res_item_t   | res_valid / res_stall
//
// One item per cycle while byte_stall is low: each byte updates the parser
// state when it is accepted, and its result (if any) is loaded into the
// result register by the same clock edge. The result register is the only storage between the two sides.
// byte_stall rises only while a result waits in that register and res_stall
// is high. arst_n clears the parser to header byte zero and empties the
// result register. The final byte of a datagram returns the parser to reset.
//
module coap_message_parser_core
	import coap_mp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  byte_item_t byte_item,
	output logic       res_valid,
	input  logic       res_stall,
	output res_item_t  res_item
);

	// Parser state
	phase_t      phase_q;
	logic [7:0]  hdr0_q;
	logic [7:0]  hdr1_q;
	logic [7:0]  hdr2_q;
	logic [3:0]  token_left_q;
	logic [15:0] running_q;
	logic [16:0] delta_acc_q;
	logic [16:0] length_acc_q;
	logic        ext_l8_q;
	logic        ext_l16_q;
	logic [16:0] value_left_q;
	logic [1:0]  sticky_q;

	// Next values before the end-of-datagram reset is applied
	phase_t      phase_n;
	logic [7:0]  hdr0_n;
	logic [7:0]  hdr1_n;
	logic [7:0]  hdr2_n;
	logic [3:0]  token_left_n;
	logic [15:0] running_n;
	logic [16:0] delta_acc_n;
	logic [16:0] length_acc_n;
	logic        ext_l8_n;
	logic        ext_l16_n;
	logic [16:0] value_left_n;
	logic [1:0]  sticky_n;

	// Result register
	logic        res_valid_q;
	res_item_t   res_item_q;

	// Option decode
	logic        ad;          // delta complete this byte
	logic        ad_l8;
	logic        ad_l16;
	logic [16:0] ad_delta;
	logic [16:0] ad_len;
	logic        fin;         // all option header bytes in
	logic [16:0] fin_delta;
	logic [16:0] fin_len;
	logic [17:0] num;
	logic        ovf;
	logic        fin_ok;

	logic        accept;
	logic [7:0]  b;
	logic        eom;
	logic [3:0]  dn;
	logic [3:0]  ln;
	logic        res_ok;
	res_item_t   res_d;

	assign b   = byte_item.data_byte;
	assign eom = byte_item.end_of_message;
	assign dn  = b[7:4];
	assign ln  = b[3:0];

	// Hold the input while a result waits and the output side is stalled.
	assign byte_stall = res_valid_q & res_stall;
	assign accept     = byte_valid & ~byte_stall;

	// ------------------------------------------------------------------
	// Option header decode: when the delta is known, and when the whole
	// option header is in, together with the running-number sum.
	// ------------------------------------------------------------------
	always_comb begin
		ad       = 1'b0;
		ad_l8    = ext_l8_q;
		ad_l16   = ext_l16_q;
		ad_delta = '0;
		ad_len   = length_acc_q;
		fin_len  = '0;
		unique case (phase_q)
			PH_OPT: begin
				if (b != PAYLOAD_MARKER && dn != NIB_RESERVED && ln != NIB_RESERVED
					&& dn != NIB_EXT8 && dn != NIB_EXT16) begin
					ad = 1'b1;
				end
				ad_l8    = (ln == NIB_EXT8);
				ad_l16   = (ln == NIB_EXT16);
				ad_delta = {13'd0, dn};
				ad_len   = {13'd0, ln};
			end
			PH_DX1: begin
				ad       = 1'b1;
				ad_delta = {9'd0, b} + EXT8_BIAS;
			end
			PH_DX2LO: begin
				ad       = 1'b1;
				ad_delta = {1'b0, delta_acc_q[15:8], b} + EXT16_BIAS;
			end
			PH_LX1:   fin_len = {9'd0, b} + EXT8_BIAS;
			PH_LX2LO: fin_len = {1'b0, length_acc_q[15:8], b} + EXT16_BIAS;
			default:  fin_len = '0;
		endcase
		if (ad) begin
			fin_len = ad_len;
		end
		fin = (ad & ~ad_l8 & ~ad_l16) | (phase_q == PH_LX1) | (phase_q == PH_LX2LO);
		fin_delta = ad ? ad_delta : delta_acc_q;
		num    = {2'b00, running_q} + {1'b0, fin_delta};
		ovf    = (num[17:16] != 2'b00);
		fin_ok = fin & ~ovf;
	end

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		phase_n      = phase_q;
		hdr0_n       = hdr0_q;
		hdr1_n       = hdr1_q;
		hdr2_n       = hdr2_q;
		token_left_n = token_left_q;
		running_n    = running_q;
		delta_acc_n  = delta_acc_q;
		length_acc_n = length_acc_q;
		ext_l8_n     = ext_l8_q;
		ext_l16_n    = ext_l16_q;
		value_left_n = value_left_q;
		sticky_n     = sticky_q;
		unique case (phase_q)
			PH_H0: begin
				hdr0_n = b;
				if (b[7:6] != COAP_VERSION) begin
					sticky_n = ST_BAD_VER;
					phase_n  = PH_SKIP;
				end else if (b[3:0] > MAX_TKL) begin
					sticky_n = ST_FORMAT;
					phase_n  = PH_SKIP;
				end else begin
					phase_n = PH_H1;
				end
			end
			PH_H1: begin
				hdr1_n  = b;
				phase_n = PH_H2;
			end
			PH_H2: begin
				hdr2_n  = b;
				phase_n = PH_H3;
			end
			PH_H3: begin
				token_left_n = hdr0_q[3:0];
				running_n    = '0;
				phase_n      = (hdr0_q[3:0] != 4'd0) ? PH_TOKEN : PH_OPT;
			end
			PH_TOKEN: begin
				token_left_n = token_left_q - 4'd1;
				if (token_left_q == 4'd1) begin
					phase_n = PH_OPT;
				end
			end
			PH_OPT: begin
				if (b == PAYLOAD_MARKER) begin
					phase_n = PH_PAYLOAD;
					// Marker on the final byte: empty payload
					if (eom) begin
						sticky_n = ST_FORMAT;
						phase_n  = PH_SKIP;
					end
				end else if (dn == NIB_RESERVED || ln == NIB_RESERVED) begin
					sticky_n = ST_FORMAT;
					phase_n  = PH_SKIP;
				end else begin
					delta_acc_n  = {13'd0, dn};
					length_acc_n = {13'd0, ln};
					ext_l8_n     = (ln == NIB_EXT8);
					ext_l16_n    = (ln == NIB_EXT16);
					if (dn == NIB_EXT8) begin
						phase_n = PH_DX1;
					end else if (dn == NIB_EXT16) begin
						phase_n = PH_DX2HI;
					end
				end
			end
			PH_DX1:   delta_acc_n = ad_delta;
			PH_DX2HI: begin
				delta_acc_n = {1'b0, b, 8'd0};
				phase_n     = PH_DX2LO;
			end
			PH_DX2LO: delta_acc_n = ad_delta;
			PH_LX1:   length_acc_n = fin_len;
			PH_LX2HI: begin
				length_acc_n = {1'b0, b, 8'd0};
				phase_n      = PH_LX2LO;
			end
			PH_LX2LO: length_acc_n = fin_len;
			PH_VALUE: begin
				value_left_n = value_left_q - 17'd1;
				if (value_left_q == 17'd1) begin
					phase_n = PH_OPT;
				end
			end
			PH_PAYLOAD: phase_n = PH_PAYLOAD;
			default:    phase_n = PH_SKIP;
		endcase

		// Delta done: go for length extension bytes, if any
		if (ad) begin
			if (ad_l8) begin
				phase_n = PH_LX1;
			end else if (ad_l16) begin
				phase_n = PH_LX2HI;
			end
		end

		// Option header complete: advance the running number or fail
		if (fin) begin
			if (ovf) begin
				sticky_n = ST_FORMAT;
				phase_n  = PH_SKIP;
			end else begin
				running_n    = num[15:0];
				value_left_n = fin_len;
				phase_n      = (fin_len != 17'd0) ? PH_VALUE : PH_OPT;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result for the accepted byte
	// ------------------------------------------------------------------
	always_comb begin
		res_d  = '0;
		res_ok = 1'b0;
		unique case (phase_q)
			PH_H3: begin
				res_ok             = 1'b1;
				res_d.event_res    = EV_HEADER;
				res_d.version      = hdr0_q[7:6];
				res_d.msg_type     = hdr0_q[5:4];
				res_d.token_length = hdr0_q[3:0];
				res_d.code_class   = hdr1_q[7:5];
				res_d.code_detail  = hdr1_q[4:0];
				res_d.msg_ident    = {hdr2_q, b};
			end
			PH_TOKEN: begin
				res_ok          = 1'b1;
				res_d.event_res = EV_TOKEN;
				res_d.out_byte  = b;
			end
			PH_VALUE: begin
				res_ok          = 1'b1;
				res_d.event_res = EV_VALUE;
				res_d.out_byte  = b;
			end
			PH_PAYLOAD: begin
				res_ok          = 1'b1;
				res_d.event_res = EV_PAYLOAD;
				res_d.out_byte  = b;
			end
			default: begin
				if (fin_ok) begin
					res_ok              = 1'b1;
					res_d.event_res     = EV_OPT;
					res_d.option_number = num[15:0];
					res_d.option_length = fin_len;
				end
			end
		endcase

		// Close the datagram: mark the last result, or report status alone
		if (eom) begin
			if (res_ok) begin
				res_d.message_done = 1'b1;
				res_d.status = (phase_n == PH_OPT || phase_n == PH_PAYLOAD) ?
					ST_OK : ST_FORMAT;
			end else begin
				res_d              = '0;
				res_ok             = 1'b1;
				res_d.event_res    = EV_STATUS;
				res_d.message_done = 1'b1;
				res_d.status       = (sticky_n != ST_OK) ? sticky_n : ST_FORMAT;
			end
		end
	end

	// ------------------------------------------------------------------
	// Parser state registers: drop everything at the end of a datagram
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_H0;
			hdr0_q       <= '0;
			hdr1_q       <= '0;
			hdr2_q       <= '0;
			token_left_q <= '0;
			running_q    <= '0;
			delta_acc_q  <= '0;
			length_acc_q <= '0;
			ext_l8_q     <= 1'b0;
			ext_l16_q    <= 1'b0;
			value_left_q <= '0;
			sticky_q     <= ST_OK;
		end else if (accept) begin
			if (eom) begin
				phase_q      <= PH_H0;
				hdr0_q       <= '0;
				hdr1_q       <= '0;
				hdr2_q       <= '0;
				token_left_q <= '0;
				running_q    <= '0;
				delta_acc_q  <= '0;
				length_acc_q <= '0;
				ext_l8_q     <= 1'b0;
				ext_l16_q    <= 1'b0;
				value_left_q <= '0;
				sticky_q     <= ST_OK;
			end else begin
				phase_q      <= phase_n;
				hdr0_q       <= hdr0_n;
				hdr1_q       <= hdr1_n;
				hdr2_q       <= hdr2_n;
				token_left_q <= token_left_n;
				running_q    <= running_n;
				delta_acc_q  <= delta_acc_n;
				length_acc_q <= length_acc_n;
				ext_l8_q     <= ext_l8_n;
				ext_l16_q    <= ext_l16_n;
				value_left_q <= value_left_n;
				sticky_q     <= sticky_n;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result register: load on a producing byte, empty when taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept && res_ok) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_ok) begin
			res_item_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

>>> tb/tb_coap_message_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoAP message parser core testbench
// Feeds datagram bytes through the parser and checks every result in order.
// A short scripted run covers header extremes and several malformed cases. A
// random run of mostly well-formed datagrams with random content follows,
// mixed with noise, truncation and reserved nibbles. A behavioral parser
// inside the bench predicts each result, and both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_coap_message_parser_core;
	import coap_mp_pkg::*;

	localparam int ITEM_GOAL = 1150;
	localparam int MAX_DGRAM = 48;
	localparam int LONG_HOLD = 150;
	localparam int TAIL_WAIT = 8;

	// One scripted row: the byte item, and an expected result where it is
	// typed in by hand rather than taken from the predictor.
	typedef struct packed {
		byte_item_t item;
		logic       typed;
		res_item_t  want;
	} script_row_t;

	logic       clk;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_stall;
	byte_item_t byte_item;
	logic       res_valid;
	logic       res_stall;
	res_item_t  res_item;

	// Hand-typed expectation that travels alongside the byte item
	logic      row_typed;
	res_item_t row_want;

	bit          idle_on;
	bit          long_hold_req;
	int          mismatches;
	res_item_t   due_results [$];
	script_row_t directed_rows [$];
	byte_item_t  datagram [$];

	// Predictor state
	phase_t      parse_phase;
	logic [31:0] hdr_word;
	logic [3:0]  tok_left;
	logic [15:0] opt_num;
	logic [16:0] delta_sum;
	logic [16:0] len_sum;
	logic        len_ext8;
	logic        len_ext16;
	logic [16:0] val_left;
	logic [1:0]  err_code;
	res_item_t   step_res;

	coap_message_parser_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void clear_parser();
		parse_phase = PH_H0;
		hdr_word = '0;
		tok_left = '0;
		opt_num = '0;
		delta_sum = '0;
		len_sum = '0;
		len_ext8 = 1'b0;
		len_ext16 = 1'b0;
		val_left = '0;
		err_code = ST_OK;
	endfunction

	// Remember the error and drop the rest of the datagram
	function automatic void abort_msg(input logic [1:0] code);
		err_code = code;
		parse_phase = PH_SKIP;
	endfunction

	// All extension bytes are in: add the delta to the running number and
	// emit the option start, unless the number leaves the 16-bit range.
	function automatic bit close_option();
		logic [17:0] num;
		num = {2'b00, opt_num} + {1'b0, delta_sum};
		if (num > 18'd65535) begin
			abort_msg(ST_FORMAT);
			return 1'b0;
		end
		opt_num = num[15:0];
		val_left = len_sum;
		step_res.event_res = EV_OPT;
		step_res.option_number = num[15:0];
		step_res.option_length = len_sum;
		if (len_sum != 17'd0) begin
			parse_phase = PH_VALUE;
		end else begin
			parse_phase = PH_OPT;
		end
		return 1'b1;
	endfunction

	// Delta complete: go on to the length extension, or finish the option
	function automatic bit delta_done();
		if (len_ext8) begin
			parse_phase = PH_LX1;
			return 1'b0;
		end
		if (len_ext16) begin
			parse_phase = PH_LX2HI;
			return 1'b0;
		end
		return close_option();
	endfunction

	// Advance the predictor by one byte; return 1 and fill step_res when the
	// byte causes a result.
	function automatic bit parse_step(input byte_item_t it);
		logic [7:0] b;
		logic [3:0] dn;
		logic [3:0] ln;
		bit         hit;
		b = it.data_byte;
		dn = b[7:4];
		ln = b[3:0];
		hit = 1'b0;
		step_res = '0;
		case (parse_phase)
			PH_H0: begin
				hdr_word = {b, 24'd0};
				if (b[7:6] != COAP_VERSION) begin
					abort_msg(ST_BAD_VER);
				end else if (b[3:0] > MAX_TKL) begin
					abort_msg(ST_FORMAT);
				end else begin
					parse_phase = PH_H1;
				end
			end
			PH_H1: begin
				hdr_word[23:16] = b;
				parse_phase = PH_H2;
			end
			PH_H2: begin
				hdr_word[15:8] = b;
				parse_phase = PH_H3;
			end
			PH_H3: begin
				hdr_word[7:0] = b;
				step_res.event_res = EV_HEADER;
				step_res.version = hdr_word[31:30];
				step_res.msg_type = hdr_word[29:28];
				step_res.token_length = hdr_word[27:24];
				step_res.code_class = hdr_word[23:21];
				step_res.code_detail = hdr_word[20:16];
				step_res.msg_ident = hdr_word[15:0];
				tok_left = hdr_word[27:24];
				opt_num = '0;
				if (tok_left != 4'd0) begin
					parse_phase = PH_TOKEN;
				end else begin
					parse_phase = PH_OPT;
				end
				hit = 1'b1;
			end
			PH_TOKEN: begin
				step_res.event_res = EV_TOKEN;
				step_res.out_byte = b;
				tok_left = tok_left - 4'd1;
				if (tok_left == 4'd0) begin
					parse_phase = PH_OPT;
				end
				hit = 1'b1;
			end
			PH_OPT: begin
				if (b == PAYLOAD_MARKER) begin
					// A marker with nothing after it is malformed
					parse_phase = PH_PAYLOAD;
					if (it.end_of_message) begin
						abort_msg(ST_FORMAT);
					end
				end else if (dn == NIB_RESERVED || ln == NIB_RESERVED) begin
					abort_msg(ST_FORMAT);
				end else begin
					delta_sum = {13'd0, dn};
					len_sum = {13'd0, ln};
					len_ext8 = (ln == NIB_EXT8);
					len_ext16 = (ln == NIB_EXT16);
					if (dn == NIB_EXT8) begin
						parse_phase = PH_DX1;
					end else if (dn == NIB_EXT16) begin
						parse_phase = PH_DX2HI;
					end else begin
						hit = delta_done();
					end
				end
			end
			PH_DX1: begin
				delta_sum = {9'd0, b} + EXT8_BIAS;
				hit = delta_done();
			end
			PH_DX2HI: begin
				delta_sum = {1'b0, b, 8'd0};
				parse_phase = PH_DX2LO;
			end
			PH_DX2LO: begin
				delta_sum = {1'b0, delta_sum[15:8], b} + EXT16_BIAS;
				hit = delta_done();
			end
			PH_LX1: begin
				len_sum = {9'd0, b} + EXT8_BIAS;
				hit = close_option();
			end
			PH_LX2HI: begin
				len_sum = {1'b0, b, 8'd0};
				parse_phase = PH_LX2LO;
			end
			PH_LX2LO: begin
				len_sum = {1'b0, len_sum[15:8], b} + EXT16_BIAS;
				hit = close_option();
			end
			PH_VALUE: begin
				step_res.event_res = EV_VALUE;
				step_res.out_byte = b;
				val_left = val_left - 17'd1;
				if (val_left == 17'd0) begin
					parse_phase = PH_OPT;
				end
				hit = 1'b1;
			end
			PH_PAYLOAD: begin
				step_res.event_res = EV_PAYLOAD;
				step_res.out_byte = b;
				hit = 1'b1;
			end
			default: begin
				parse_phase = PH_SKIP;
			end
		endcase

		// The final byte always reports. It is fine only when the parser
		// stands between options or inside the payload; a byte with no
		// result of its own becomes a status-only result.
		if (it.end_of_message) begin
			if (hit) begin
				step_res.message_done = 1'b1;
				if (parse_phase == PH_OPT || parse_phase == PH_PAYLOAD) begin
					step_res.status = ST_OK;
				end else begin
					step_res.status = ST_FORMAT;
				end
			end else begin
				step_res = '0;
				step_res.event_res = EV_STATUS;
				step_res.message_done = 1'b1;
				step_res.status = (err_code != ST_OK) ? err_code : ST_FORMAT;
				hit = 1'b1;
			end
			clear_parser();
		end
		return hit;
	endfunction

	// ------------------------------------------------------------------
	// Scripted rows
	// ------------------------------------------------------------------

	function automatic res_item_t status_res(input logic [1:0] st);
		res_item_t r;
		r = '0;
		r.event_res = EV_STATUS;
		r.message_done = 1'b1;
		r.status = st;
		return r;
	endfunction

	function automatic res_item_t header_res(input logic [1:0] ty, input logic [3:0] tkl,
			input logic [7:0] code, input logic [15:0] mid);
		res_item_t r;
		r = '0;
		r.event_res = EV_HEADER;
		r.version = COAP_VERSION;
		r.msg_type = ty;
		r.token_length = tkl;
		r.code_class = code[7:5];
		r.code_detail = code[4:0];
		r.msg_ident = mid;
		return r;
	endfunction

	task automatic add_row(input logic [7:0] b, input logic eom, input logic typed,
			input res_item_t want);
		script_row_t row;
		row.item.data_byte = b;
		row.item.end_of_message = eom;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// ------------------------------------------------------------------
	// Random datagrams
	// ------------------------------------------------------------------

	// Append a byte unless the datagram has reached its size cap; a value
	// too long for the cap leaves the datagram truncated.
	task automatic put_byte(input logic [7:0] b);
		byte_item_t it;
		if (datagram.size() < MAX_DGRAM) begin
			it.data_byte = b;
			it.end_of_message = 1'b0;
			datagram.push_back(it);
		end
	endtask

	task automatic put_option();
		logic [3:0] dn;
		logic [3:0] ln;
		logic [7:0] ext_bytes [$];
		logic [7:0] hi;
		logic [7:0] lo;
		int         roll;
		int         vlen;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			dn = 4'($urandom_range(0, 12));
		end else if (roll < 82) begin
			dn = NIB_EXT8;
			ext_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			// Large deltas soon push the running number past 16 bits
			dn = NIB_EXT16;
			ext_bytes.push_back(8'($urandom_range(0, 255)));
			ext_bytes.push_back(8'($urandom_range(0, 255)));
		end
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			ln = 4'($urandom_range(0, 12));
			vlen = int'(ln);
		end else if (roll < 94) begin
			// Mostly short values, now and then one that runs into the cap
			ln = NIB_EXT8;
			lo = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 6));
			ext_bytes.push_back(lo);
			vlen = int'(lo) + 13;
		end else begin
			ln = NIB_EXT16;
			hi = 8'($urandom_range(0, 255));
			lo = 8'($urandom_range(0, 255));
			ext_bytes.push_back(hi);
			ext_bytes.push_back(lo);
			vlen = int'({hi, lo}) + 269;
		end
		// Poison one nibble with the reserved value now and then
		if ($urandom_range(0, 99) < 4) begin
			if ($urandom_range(0, 1) == 1) begin
				dn = NIB_RESERVED;
			end else begin
				ln = NIB_RESERVED;
			end
		end
		put_byte({dn, ln});
		foreach (ext_bytes[i]) begin
			put_byte(ext_bytes[i]);
		end
		for (int i = 0; i < vlen && datagram.size() < MAX_DGRAM; i++) begin
			put_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Build the next datagram: mostly well-formed with random content, the
	// rest noise, wrong versions, oversized tokens and truncated tails.
	task automatic build_datagram();
		byte_item_t it;
		logic [7:0] b0;
		int         kind;
		int         roll;
		int         cut;
		datagram.delete();
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 12)) begin
				put_byte(8'($urandom_range(0, 255)));
			end
		end else begin
			b0 = {COAP_VERSION, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 8))};
			if (kind < 13) begin
				b0[7:6] = 2'($urandom_range(0, 2));
				if (b0[7:6] == COAP_VERSION) begin
					b0[7:6] = 2'd3;
				end
			end else if (kind < 18) begin
				b0[3:0] = 4'($urandom_range(9, 15));
			end
			put_byte(b0);
			repeat (3) begin
				put_byte(8'($urandom_range(0, 255)));
			end
			repeat (b0[3:0]) begin
				put_byte(8'($urandom_range(0, 255)));
			end
			repeat ($urandom_range(0, 4)) begin
				put_option();
			end
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				put_byte(PAYLOAD_MARKER);
				repeat ($urandom_range(1, 10)) begin
					put_byte(8'($urandom_range(0, 255)));
				end
			end else if (roll < 62) begin
				put_byte(PAYLOAD_MARKER);
			end
			if ($urandom_range(0, 99) < 10) begin
				cut = $urandom_range(1, datagram.size());
				while (datagram.size() > cut) begin
					void'(datagram.pop_back());
				end
			end
		end
		// Mark the final byte
		it = datagram.pop_back();
		it.end_of_message = 1'b1;
		datagram.push_back(it);
	endtask

	// ------------------------------------------------------------------
	// Byte side
	// ------------------------------------------------------------------

	// Offer one item, idling first at random, and hold it until accepted
	task automatic offer(input byte_item_t it, input logic typed, input res_item_t want);
		while (idle_on && $urandom_range(0, 99) < 24) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= it;
		row_typed <= typed;
		row_want <= want;
		@(posedge clk);
		while (byte_stall) begin
			@(posedge clk);
		end
	endtask

	// Drop valid and hold until every expected result has come back
	task automatic drain_results();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls, plus one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				// Hold off long enough that the result register fills and
				// the parser has to stall its byte side
				long_hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (LONG_HOLD) begin
					@(posedge clk);
				end
			end
			res_stall <= arst_n && idle_on && ($urandom_range(0, 99) < 24);
		end
	end

	// ------------------------------------------------------------------
	// Scoreboard: check the result first, then predict the accepted byte
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [16:0] want,
			input logic [16:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns  %s  expected %0d  actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		res_item_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (due_results.size() == 0) begin
					mismatches++;
					$display("%0t ns  result with none due  expected none  actual event %0d byte %0h status %0d",
						$time, res_item.event_res, res_item.out_byte, res_item.status);
				end else begin
					want = due_results.pop_front();
					check_field("event_res", 17'(want.event_res),
						17'(res_item.event_res));
					check_field("version", 17'(want.version), 17'(res_item.version));
					check_field("msg_type", 17'(want.msg_type), 17'(res_item.msg_type));
					check_field("token_length", 17'(want.token_length),
						17'(res_item.token_length));
					check_field("code_class", 17'(want.code_class),
						17'(res_item.code_class));
					check_field("code_detail", 17'(want.code_detail),
						17'(res_item.code_detail));
					check_field("msg_ident", 17'(want.msg_ident),
						17'(res_item.msg_ident));
					check_field("option_number", 17'(want.option_number),
						17'(res_item.option_number));
					check_field("option_length", want.option_length,
						res_item.option_length);
					check_field("out_byte", 17'(want.out_byte), 17'(res_item.out_byte));
					check_field("message_done", 17'(want.message_done),
						17'(res_item.message_done));
					check_field("status", 17'(want.status), 17'(res_item.status));
				end
			end
			if (byte_valid && !byte_stall) begin
				if (parse_step(byte_item)) begin
					due_results.push_back(row_typed ? row_want : step_res);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int msgs;
		int sent;
		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		byte_item <= '0;
		row_typed <= 1'b0;
		row_want <= '0;
		idle_on = 1'b1;
		long_hold_req = 1'b0;
		mismatches = 0;
		clear_parser();

		// Version 3, token length 9, and a header cut short after one byte
		add_row(8'hFF, 1'b1, 1'b1, status_res(ST_BAD_VER));
		add_row(8'h49, 1'b1, 1'b1, status_res(ST_FORMAT));
		add_row(8'h50, 1'b1, 1'b1, status_res(ST_FORMAT));
		// Header with all-ones type, code and ID, one token byte, a 16-bit delta landing exactly on
		// 65535 with a one-byte value, and no payload
		add_row(8'h71, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b0, 1'b1, header_res(2'd3, 4'd1, 8'hFF, 16'hFFFF));
		add_row(8'hA5, 1'b0, 1'b0, '0);
		add_row(8'hE1, 1'b0, 1'b0, '0);
		add_row(8'hFE, 1'b0, 1'b0, '0);
		add_row(8'hF2, 1'b0, 1'b0, '0);
		add_row(8'h3C, 1'b1, 1'b0, '0);
		// All-zero header, an 8-bit delta extension, then a reserved length
		add_row(8'h40, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b1, header_res(2'd0, 4'd0, 8'h00, 16'h0000));
		add_row(8'hD0, 1'b0, 1'b0, '0);
		add_row(8'h05, 1'b0, 1'b0, '0);
		add_row(8'h1F, 1'b1, 1'b1, status_res(ST_FORMAT));
		// Payload marker on the final byte
		add_row(8'h40, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'h00, 1'b0, 1'b0, '0);
		add_row(8'hFF, 1'b1, 1'b1, status_res(ST_FORMAT));

		repeat (2) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
		end
		drain_results();

		// Random datagrams until enough bytes have been offered
		msgs = 0;
		sent = 0;
		while (sent < ITEM_GOAL) begin
			if (msgs == 8) begin
				long_hold_req = 1'b1;
			end
			if (msgs == 16) begin
				idle_on = 1'b0;
			end
			if (msgs == 28) begin
				idle_on = 1'b1;
			end
			if (msgs == 36) begin
				drain_results();
			end
			build_datagram();
			foreach (datagram[i]) begin
				offer(datagram[i], 1'b0, '0);
			end
			sent += datagram.size();
			msgs++;
		end

		drain_results();
		repeat (TAIL_WAIT) begin
			@(posedge clk);
		end
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
